// File: design/dss_pkg.sv
// Shared types and constants for the dual stack shared memory block.
// No dependencies; imported by every module of the block.
package dss_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned STAT_W   = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load_out;
  } dss_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dss_stat_t;

endpackage

// File: design/dual_stack_shared_memory.sv
// Top level of the dual stack shared memory block.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
//
// Two LIFO stacks share one store of CAPACITY words: the first grows up
// from entry zero, the second grows down from the last entry.
// The slave channel takes one request per push or pop: tuser[0] is the
// opcode, tuser[1] selects the stack and tdata carries the word to push.
// The master channel returns one result per request: tdata holds the
// popped word and both empty flags, tuser holds the status.
// A request is accepted in the idle state and does its store access in
// that cycle; the result enters the output register from the execute state,
// so no new request is taken until the last result has been loaded.
// The execute state is set by the registered read port of the shared store.
// While the receiver stalls, the result waits in the output register and
// one further request is still accepted; the block then holds tready low
// until the output register frees up.
// Reset empties both stacks and the output register; the store itself
// is not cleared and needs no clearing pass.
module dual_stack_shared_memory import dss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // push_value[31:0]
  input  logic [1:0]  s_axis_tuser_i,   // opcode[0], stack_select[1]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // pop_value[31:0], first_empty[32],
                                        // second_empty[33], zero[39:34]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  dss_cmd_t          cmd;
  dss_stat_t         stat;
  logic [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0] status;
  logic              first_empty, second_empty;

  dss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd)
  );

  dss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (s_axis_tuser_i[0]),
    .stack_select_i (s_axis_tuser_i[1]),
    .push_value_i   (s_axis_tdata_i),
    .out_ready_i    (m_axis_tready_i),
    .stat_o         (stat),
    .pop_value_o    (pop_value),
    .status_o       (status),
    .first_empty_o  (first_empty),
    .second_empty_o (second_empty)
  );

  assign m_axis_tvalid_o = stat.out_valid;
  assign m_axis_tdata_o  = {6'b0, second_empty, first_empty, pop_value};
  assign m_axis_tuser_o  = status;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK || m_axis_tuser_o == ST_FULL ||
                         m_axis_tuser_o == ST_EMPTY))
    else $error("result status is not a defined code");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_OK) |-> (m_axis_tdata_o[31:0] == '0))
    else $error("refused request returned a nonzero word");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while another is in progress");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> m_axis_tvalid_o)
    else $error("loaded result not presented");

endmodule

// File: design/dss_ctrl.sv
// Controller state machine of the dual stack shared memory block.
// Depends on dss_pkg; drives the datapath through dss_cmd_t.
module dss_ctrl import dss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  input  dss_stat_t stat_i,
  output logic      in_ready_o,
  output dss_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_free;

  assign out_free = !stat_i.out_valid || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/dss_datapath.sv
// Datapath of the dual stack shared memory block: counts, shared store, result register.
// Depends on dss_pkg; commanded by dss_ctrl.
module dss_datapath import dss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dss_cmd_t          cmd_i,
  input  logic              opcode_i,
  input  logic              stack_select_i,
  input  logic [DATA_W-1:0] push_value_i,
  input  logic              out_ready_i,
  output dss_stat_t         stat_o,
  output logic [DATA_W-1:0] pop_value_o,
  output logic [STAT_W-1:0] status_o,
  output logic              first_empty_o,
  output logic              second_empty_o
);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]  first_cnt_q, first_cnt_d;
  logic [CNT_W-1:0]  second_cnt_q, second_cnt_d;
  logic [CNT_W:0]    total;
  logic              is_full;
  logic              push_ok, pop_ok;
  logic [CNT_W-1:0]  slot;
  logic [ADDR_W-1:0] addr;
  status_e           status_d;

  logic [DATA_W-1:0] rdata_q;
  logic              pop_ok_q;
  status_e           status_q;
  logic              fe_q, se_q;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic [STAT_W-1:0] out_status_q;
  logic              out_fe_q, out_se_q;

  assign total   = {1'b0, first_cnt_q} + {1'b0, second_cnt_q};
  assign is_full = total >= (CNT_W+1)'(CAPACITY);

  always_comb begin
    push_ok      = 1'b0;
    pop_ok       = 1'b0;
    status_d     = ST_OK;
    slot         = first_cnt_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    if (opcode_i == OP_PUSH) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else if (!stack_select_i) begin
        push_ok     = 1'b1;
        slot        = first_cnt_q;
        first_cnt_d = first_cnt_q + 1'b1;
      end else begin
        push_ok      = 1'b1;
        slot         = CNT_W'(CAPACITY - 1) - second_cnt_q;
        second_cnt_d = second_cnt_q + 1'b1;
      end
    end else begin
      if (!stack_select_i) begin
        if (first_cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok      = 1'b1;
          slot        = first_cnt_q - 1'b1;
          first_cnt_d = first_cnt_q - 1'b1;
        end
      end else begin
        if (second_cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          pop_ok       = 1'b1;
          slot         = CNT_W'(CAPACITY) - second_cnt_q;
          second_cnt_d = second_cnt_q - 1'b1;
        end
      end
    end
  end

  assign addr = slot[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && push_ok) begin
      mem[addr] <= push_value_i;
    end
    if (cmd_i.accept && pop_ok) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pop_ok_q <= pop_ok;
      status_q <= status_d;
      fe_q     <= (first_cnt_d == '0);
      se_q     <= (second_cnt_d == '0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q  <= pop_ok_q ? rdata_q : '0;
      out_status_q <= status_q;
      out_fe_q     <= fe_q;
      out_se_q     <= se_q;
    end
  end

  assign stat_o.out_valid = out_valid_q;
  assign pop_value_o      = out_value_q;
  assign status_o         = out_status_q;
  assign first_empty_o    = out_fe_q;
  assign second_empty_o   = out_se_q;

endmodule
